### rtl/kmcc_pkg.sv
// Shared types and constants for the k-way merge count combiner.
package kmcc_pkg;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int MIN_COUNT_W = 32;
   localparam int LISTS_W     = 5;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LISTS     = 2'd1;

   localparam logic [LISTS_W-1:0] LISTS_RESET = 5'd2;

   localparam logic CMD_ELEM = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic take;
      logic scan_start;
      logic scan_step;
      logic post_idle;
      logic post_merge;
   } ctl_cmd_type;

   typedef struct packed {
      logic merge_ready;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/kmcc_ctrl.sv
// Controller state machine: sequences word intake, head scan and result posting.
module kmcc_ctrl
   import kmcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = reset || (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.take = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.merge_ready) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (sts.out_free) begin
               cmd.post_idle = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.post_merge = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/kmcc_datapath.sv
// Datapath: list heads, config registers, min/sum scan unit and output word register.
module kmcc_datapath
   import kmcc_pkg::*;
#(
   parameter int MAX_LISTS  = 16,
   parameter int KEY_BITS   = 62,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_cmd_type                   cmd,
   output dp_status_type                 sts,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_cmd,
   input  logic [$clog2(MAX_LISTS)-1:0]  req_list_id,
   input  logic [KEY_BITS-1:0]           req_key_in,
   input  logic [COUNT_BITS-1:0]         req_count_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_emit_valid,
   output logic [KEY_BITS-1:0]           rsp_key_out,
   output logic [COUNT_BITS-1:0]         rsp_count_out,
   output logic                          rsp_dropped,
   output logic [MAX_LISTS-1:0]          rsp_refill_mask,
   output logic                          rsp_all_done
);

   localparam int ID_W  = $clog2(MAX_LISTS);
   localparam int CNT_W = $clog2(MAX_LISTS + 1);
   localparam int CMP_W = (COUNT_BITS > MIN_COUNT_W) ? COUNT_BITS : MIN_COUNT_W;

   logic [MIN_COUNT_W-1:0] min_count_ff;
   logic [LISTS_W-1:0]     lists_ff;

   logic [KEY_BITS-1:0]    head_key_ff   [MAX_LISTS];
   logic [COUNT_BITS-1:0]  head_count_ff [MAX_LISTS];

   logic [MAX_LISTS-1:0]   present_ff, present_in;
   logic [MAX_LISTS-1:0]   ended_ff, ended_in;
   logic [MAX_LISTS-1:0]   match_ff, match_in;
   logic [ID_W-1:0]        idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [KEY_BITS-1:0]    best_ff, best_in;
   logic [COUNT_BITS-1:0]  sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   rsp_emit_valid_ff;
   logic [KEY_BITS-1:0]    rsp_key_out_ff;
   logic [COUNT_BITS-1:0]  rsp_count_out_ff;
   logic                   rsp_dropped_ff;
   logic [MAX_LISTS-1:0]   rsp_refill_mask_ff;
   logic                   rsp_all_done_ff;

   logic [CNT_W-1:0]       n_active;
   logic [MAX_LISTS-1:0]   act;
   logic [MAX_LISTS-1:0]   live;
   logic [MAX_LISTS-1:0]   waiting;
   logic [MAX_LISTS-1:0]   pres_after;
   logic [MAX_LISTS-1:0]   idx_bit;
   logic                   id_ok;
   logic                   take_ok;
   logic [KEY_BITS-1:0]    scan_key;
   logic [COUNT_BITS-1:0]  scan_count;
   logic [COUNT_BITS:0]    sum_ext;
   logic [COUNT_BITS-1:0]  sum_sat;
   logic                   pass;
   logic                   post;

   // active list count, clamped to [2, MAX_LISTS]
   always_comb begin
      if (lists_ff < LISTS_W'(2)) begin
         n_active = CNT_W'(2);
      end else if (32'(lists_ff) > MAX_LISTS) begin
         n_active = CNT_W'(MAX_LISTS);
      end else begin
         n_active = CNT_W'(lists_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_LISTS; i++) begin
         act[i] = (CNT_W'(i) < n_active);
      end
   end

   assign live    = act & present_ff;
   assign waiting = act & ~present_ff & ~ended_ff;
   assign idx_bit = MAX_LISTS'(1) << idx_ff;

   assign id_ok   = CNT_W'(req_list_id) < n_active;
   assign take_ok = cmd.take && id_ok && !present_ff[req_list_id] && !ended_ff[req_list_id];

   assign scan_key   = head_key_ff[idx_ff];
   assign scan_count = head_count_ff[idx_ff];
   assign sum_ext    = {1'b0, sum_ff} + {1'b0, scan_count};
   assign sum_sat    = sum_ext[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_ext[COUNT_BITS-1:0];

   assign pass       = CMP_W'(sum_ff) >= CMP_W'(min_count_ff);
   assign post       = cmd.post_idle || cmd.post_merge;
   assign pres_after = cmd.post_merge ? (present_ff & ~match_ff) : present_ff;

   assign sts.merge_ready = (waiting == '0) && (live != '0);
   assign sts.scan_last   = CNT_W'(idx_ff) == (n_active - CNT_W'(1));
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      present_in   = present_ff;
      ended_in     = ended_ff;
      match_in     = match_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (take_ok) begin
         if (req_cmd == CMD_END) begin
            ended_in[req_list_id] = 1'b1;
         end else begin
            present_in[req_list_id] = 1'b1;
         end
      end

      if (cmd.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
         match_in = '0;
         best_in  = '0;
         sum_in   = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + ID_W'(1);
         if (live[idx_ff]) begin
            if (!found_ff || (scan_key < best_ff)) begin
               found_in = 1'b1;
               best_in  = scan_key;
               sum_in   = scan_count;
               match_in = idx_bit;
            end else if (scan_key == best_ff) begin
               sum_in   = sum_sat;
               match_in = match_ff | idx_bit;
            end
         end
      end

      if (cmd.post_merge) begin
         present_in = present_ff & ~match_ff;
      end

      if (post) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= '0;
         lists_ff     <= LISTS_RESET;
         present_ff   <= '0;
         ended_ff     <= '0;
         match_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == REG_MIN_COUNT)) begin
            min_count_ff <= csr_wdata[MIN_COUNT_W-1:0];
         end
         if (csr_we && (csr_index == REG_LISTS)) begin
            lists_ff <= csr_wdata[LISTS_W-1:0];
         end
         present_ff   <= present_in;
         ended_ff     <= ended_in;
         match_ff     <= match_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      sum_ff  <= sum_in;
      if (take_ok && (req_cmd == CMD_ELEM)) begin
         head_key_ff[req_list_id]   <= req_key_in;
         head_count_ff[req_list_id] <= req_count_in;
      end
      if (post) begin
         rsp_emit_valid_ff  <= cmd.post_merge && pass;
         rsp_dropped_ff     <= cmd.post_merge && !pass;
         rsp_key_out_ff     <= cmd.post_merge ? best_ff : '0;
         rsp_count_out_ff   <= cmd.post_merge ? sum_ff : '0;
         rsp_refill_mask_ff <= act & ~pres_after & ~ended_ff;
         rsp_all_done_ff    <= ((ended_ff & act) == act) && ((pres_after & act) == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_emit_valid  = rsp_emit_valid_ff;
   assign rsp_key_out     = rsp_key_out_ff;
   assign rsp_count_out   = rsp_count_out_ff;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_refill_mask = rsp_refill_mask_ff;
   assign rsp_all_done    = rsp_all_done_ff;

   a_merge_has_match: assert property (@(posedge clock) disable iff (reset)
      cmd.post_merge |-> (match_ff != '0))
      else $error("merge posted with no matching head");

   a_consumed_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.post_merge |=> ((present_ff & $past(match_ff)) == '0))
      else $error("consumed head still present");

   a_emit_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_emit_valid_ff && rsp_dropped_ff))
      else $error("word both emitted and dropped");

   a_done_no_refill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_all_done_ff) |-> (rsp_refill_mask_ff == '0))
      else $error("refill requested after all lists done");

endmodule

### rtl/kway_merge_count_combiner.sv
// K-way merge of sorted key/count lists with duplicate-count reduction.
//
// req_* channel: one word per list event (element or end mark for req_list_id),
// taken when req_valid is high and req_stall is low. rsp_* channel: one result
// word per request word, taken when rsp_valid is high and rsp_stall is low.
// csr_* port: csr_we writes csr_wdata to register csr_index (0 = min_count,
// 1 = lists_in_use); write only while idle.
// Sequence: a word that triggers no merge is evaluated and its result posted to
// the output register. A merge scans the n active list heads one per cycle
// through a single key comparator and saturating adder, then posts the merged
// result (n = lists_in_use clamped to 2..MAX_LISTS). The next request word can
// be taken in the same cycle in which the previous result appears in the
// output register.
// A held result stays in the output register while rsp_stall is high; a new
// request can still be taken, and its result waits until the register frees.
// Reset (synchronous) clears all heads and end marks, sets min_count to 0 and
// lists_in_use to 2; req_stall is high while reset is asserted.
module kway_merge_count_combiner
   import kmcc_pkg::*;
#(
   parameter int MAX_LISTS  = 16,
   parameter int KEY_BITS   = 62,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [$clog2(MAX_LISTS)-1:0]  req_list_id,
   input  logic [KEY_BITS-1:0]           req_key_in,
   input  logic [COUNT_BITS-1:0]         req_count_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_emit_valid,
   output logic [KEY_BITS-1:0]           rsp_key_out,
   output logic [COUNT_BITS-1:0]         rsp_count_out,
   output logic                          rsp_dropped,
   output logic [MAX_LISTS-1:0]          rsp_refill_mask,
   output logic                          rsp_all_done
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   kmcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kmcc_datapath #(
      .MAX_LISTS  (MAX_LISTS),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_list_id     (req_list_id),
      .req_key_in      (req_key_in),
      .req_count_in    (req_count_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_emit_valid  (rsp_emit_valid),
      .rsp_key_out     (rsp_key_out),
      .rsp_count_out   (rsp_count_out),
      .rsp_dropped     (rsp_dropped),
      .rsp_refill_mask (rsp_refill_mask),
      .rsp_all_done    (rsp_all_done)
   );

endmodule
